// ----- rtl/crce_pkg.sv -----
// Shared types and constants of the CRC codeword encoder.
package crce_pkg;

	localparam int MAX_GENERATOR_LENGTH = 17;
	localparam int REM_W                = MAX_GENERATOR_LENGTH - 1;
	localparam int GEN_W                = 17;
	localparam int LEN_W                = 5;
	localparam int BYTE_BITS            = 8;
	localparam int NIBBLE_BITS          = 4;
	localparam int CW_W                 = 24;
	localparam int CWL_W                = 5;
	localparam int CFG_IDX_W            = 2;
	localparam int QUEUE_DEPTH          = 2;
	localparam int PTR_W                = $clog2(QUEUE_DEPTH);
	localparam int CNT_W                = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_GENERATOR_BITS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GENERATOR_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NIBBLE_MODE      = 2'd2;

	typedef struct packed {
		logic [GEN_W-1:0] generator_bits;
		logic [LEN_W-1:0] generator_length;
		logic             nibble_mode;
	} crce_cfg_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] data;
		logic                 nibble;
	} crce_item_t;

endpackage

// ----- rtl/crce_front.sv -----
// Front end: accepts bytes, tags them with their dataword mode and queues them.
module crce_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [crce_pkg::BYTE_BITS-1:0] data_byte,
	input  logic                          nibble_mode,
	output logic                          item_valid,
	output crce_pkg::crce_item_t          item,
	input  logic                          pop
);
	import crce_pkg::*;

	localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);

	crce_item_t       mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             do_pop;

	assign busy       = (count_q == FULL);
	assign push       = start && !busy;
	assign item_valid = (count_q != '0);
	assign item       = mem_q[rd_ptr_q];
	assign do_pop     = pop && item_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q].data   <= data_byte;
			mem_q[wr_ptr_q].nibble <= nibble_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/crce_back.sv -----
// Back end: divides each dataword by the generator and registers the codeword.
module crce_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  crce_pkg::crce_cfg_t        cfg,
	input  logic                       item_valid,
	input  crce_pkg::crce_item_t       item,
	output logic                       pop,
	output logic                       valid,
	output logic [crce_pkg::CW_W-1:0]  codeword,
	output logic [crce_pkg::CWL_W-1:0] codeword_length,
	output logic                       last_of_byte
);
	import crce_pkg::*;

	function automatic logic [REM_W-1:0] crc_rem(
		input logic [BYTE_BITS-1:0] data,
		input logic                 is_nibble,
		input logic [REM_W-1:0]     poly
	);
		logic [REM_W-1:0] rem;
		logic             fb;
		rem = '0;
		for (int i = 0; i < BYTE_BITS; i++) begin
			if (!is_nibble || i < NIBBLE_BITS) begin
				fb  = data[BYTE_BITS-1-i] ^ rem[REM_W-1];
				rem = {rem[REM_W-2:0], 1'b0} ^ (fb ? poly : '0);
			end
		end
		return rem;
	endfunction

	logic                 phase_q;
	logic [LEN_W-1:0]     eff_len;
	logic [LEN_W-1:0]     r;
	logic [LEN_W-1:0]     lj_shift;
	logic [REM_W:0]       mask_w;
	logic [REM_W-1:0]     poly_lj;
	logic [BYTE_BITS-1:0] word;
	logic [BYTE_BITS-1:0] word_aligned;
	logic                 first_half;
	logic [REM_W-1:0]     rem_lj;
	logic [REM_W-1:0]     rem;

	always_comb begin
		if (cfg.generator_length < LEN_W'(2)) begin
			eff_len = LEN_W'(2);
		end else if (cfg.generator_length > LEN_W'(MAX_GENERATOR_LENGTH)) begin
			eff_len = LEN_W'(MAX_GENERATOR_LENGTH);
		end else begin
			eff_len = cfg.generator_length;
		end
	end

	assign r        = eff_len - LEN_W'(1);
	assign lj_shift = LEN_W'(REM_W) - r;
	assign mask_w   = ((REM_W+1)'(1) << r) - (REM_W+1)'(1);
	assign poly_lj  = (REM_W'(cfg.generator_bits) & mask_w[REM_W-1:0]) << lj_shift;

	assign first_half = item.nibble && !phase_q;
	assign pop        = item_valid && !first_half;

	always_comb begin
		if (!item.nibble) begin
			word = item.data;
		end else if (first_half) begin
			word = {{(BYTE_BITS-NIBBLE_BITS){1'b0}}, item.data[BYTE_BITS-1:NIBBLE_BITS]};
		end else begin
			word = {{(BYTE_BITS-NIBBLE_BITS){1'b0}}, item.data[NIBBLE_BITS-1:0]};
		end
		word_aligned = item.nibble ? (word << (BYTE_BITS - NIBBLE_BITS)) : word;
	end

	assign rem_lj = crc_rem(word_aligned, item.nibble, poly_lj);
	assign rem    = rem_lj >> lj_shift;

	always_ff @(posedge clk) begin
		if (item_valid) begin
			codeword        <= (CW_W'(word) << r) | CW_W'(rem);
			codeword_length <= (item.nibble ? CWL_W'(NIBBLE_BITS) : CWL_W'(BYTE_BITS))
				+ CWL_W'(r);
			last_of_byte    <= !first_half;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			valid   <= 1'b0;
		end else begin
			valid <= item_valid;
			if (item_valid) begin
				phase_q <= first_half;
			end
		end
	end

endmodule

// ----- rtl/crc_codeword_encoder.sv -----
// Top level of the CRC codeword encoder with a programmable generator.
// Usage: raise start with data_byte while busy is low; the byte is taken at
// that clock edge as one transaction and waits in a two-entry queue.
// The back end turns each byte into codewords, one per cycle: one codeword
// in 8-bit mode, or two in nibble mode (high nibble first, then low nibble).
// Each codeword is shown for exactly one cycle with valid high, together with
// codeword_length and last_of_byte, which marks the final codeword of a byte.
// Each byte passes the queue entry, then the back-end output register.
// Throughput is one byte per cycle in 8-bit mode; in nibble mode each byte
// holds the single result port of the back end for both of its codewords.
// Busy rises only when the queue holds two bytes not yet fully encoded.
// The receiver cannot stall, so results are never held back.
// Registers must be written through cfg_we, cfg_index and cfg_data while the
// block is idle, which it does not enforce; unknown indexes are ignored.
// Reset empties the queue, clears valid and loads the generator 0x11021 with
// length 17 in 8-bit mode.
module crc_codeword_encoder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [crce_pkg::BYTE_BITS-1:0] data_byte,
	input  logic                           cfg_we,
	input  logic [crce_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [crce_pkg::GEN_W-1:0]     cfg_data,
	output logic                           valid,
	output logic [crce_pkg::CW_W-1:0]      codeword,
	output logic [crce_pkg::CWL_W-1:0]     codeword_length,
	output logic                           last_of_byte
);
	import crce_pkg::*;

	crce_cfg_t  cfg_q;
	crce_item_t item;
	logic       item_valid;
	logic       pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.generator_bits   <= GEN_W'(69665);
			cfg_q.generator_length <= LEN_W'(17);
			cfg_q.nibble_mode      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GENERATOR_BITS:   cfg_q.generator_bits   <= cfg_data;
				REG_GENERATOR_LENGTH: cfg_q.generator_length <= cfg_data[LEN_W-1:0];
				REG_NIBBLE_MODE:      cfg_q.nibble_mode      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	crce_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.data_byte   (data_byte),
		.nibble_mode (cfg_q.nibble_mode),
		.item_valid  (item_valid),
		.item        (item),
		.pop         (pop)
	);

	crce_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.item_valid      (item_valid),
		.item            (item),
		.pop             (pop),
		.valid           (valid),
		.codeword        (codeword),
		.codeword_length (codeword_length),
		.last_of_byte    (last_of_byte)
	);

	a_nibble_pair: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last_of_byte |=> valid && last_of_byte)
		else $error("First nibble codeword was not followed by the second one.");

	a_first_only_nibble: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last_of_byte |-> cfg_q.nibble_mode)
		else $error("Codeword without last mark outside nibble mode.");

	a_codeword_fits: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (codeword >> codeword_length) == '0)
		else $error("Codeword has bits above its reported length.");

endmodule
